// ----- hdl/spa_pkg.sv -----
// Shared types and constants for the sparse polynomial adder.
// No dependencies; imported by every module of the block.
package spa_pkg;

  localparam int unsigned TERMS_PER_POLY_DEF = 32;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned EXPON_W = 16;
  localparam int unsigned SUM_W = COEF_W + 1;

  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_RUN    = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MERGE,
    ST_FINISH
  } state_e;

  // One stored term: coefficient in the low half, exponent in the high half.
  typedef struct packed {
    logic [EXPON_W-1:0]       expon;
    logic signed [COEF_W-1:0] coef;
  } term_t;

  // One merged term waiting to go out.
  typedef struct packed {
    logic                     term_valid;
    logic signed [SUM_W-1:0]  coef;
    logic [EXPON_W-1:0]       expon;
  } res_t;

endpackage

// ----- hdl/spa_store.sv -----
// Term store: single-port write, single-port registered read memory.
// Depends on spa_pkg for the term type.
module spa_store #(
  parameter int unsigned DEPTH = spa_pkg::TERMS_PER_POLY_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  spa_pkg::term_t wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output spa_pkg::term_t rdata_o
);
  import spa_pkg::*;

  term_t mem_q [DEPTH];
  term_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/sparse_polynomial_adder_unit.sv -----
// Sparse polynomial adder: sorted merge of two term stores by exponent.
// Loads: one word per cycle, back to back; ready stays high while idle.
// A run alternates a fetch state (one store read) and a merge state (one
// compare/add) per merge step, then finishes; matching exponents take a term
// from each store in one step. Each store's single read port and the one shared
// compare/add unit pace a run; output stalls hold a step; at most one term a step.
// Reset (rst_ni low, asynchronous): stores empty, overflow flag clear, idle.
module sparse_polynomial_adder_unit #(
  parameter int unsigned TERMS_PER_POLY = spa_pkg::TERMS_PER_POLY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] term_coef, [31:16] term_expon
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // Master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [16:0] out_coef, [32:17] out_expon, rest zero
  output logic [1:0]  m_axis_tuser,   // [0] term_valid, [1] load_overflow
  output logic        m_axis_tlast    // last_term
);
  import spa_pkg::*;

  localparam int unsigned AW = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
  localparam int unsigned CW = $clog2(TERMS_PER_POLY + 1);
  localparam logic [CW-1:0] FULL = CW'(TERMS_PER_POLY);

  // Sequencer and control state
  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0]  idx_a_q, idx_a_d, idx_b_q, idx_b_d;
  logic           ovf_q, ovf_d;
  logic           pend_vld_q, pend_vld_d;
  logic           out_vld_q, out_vld_d;

  // Payload registers
  res_t           pend_q, pend_d;
  res_t           out_res_q, out_res_d;
  logic           out_last_q, out_last_d;
  logic           out_ovf_q, out_ovf_d;

  // Input decode
  logic           s_acc;
  req_e           req;
  term_t          in_term;
  logic           we_a, we_b;

  // Store read side
  term_t          rd_a, rd_b;

  // Shared compare/add unit
  logic                    a_has, b_has;
  logic signed [SUM_W-1:0] coef_a_x, coef_b_x, sum;
  logic                    a_gt, a_lt;

  // Merge step outcome
  logic           emit, adv_a, adv_b, done;
  res_t           new_res;
  logic           slot_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign req           = req_e'(s_axis_tuser);
  assign in_term.coef  = s_axis_tdata[15:0];
  assign in_term.expon = s_axis_tdata[31:16];

  // Drop a load into a full store; the run flags it.
  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    unique case (req)
      REQ_LOAD_A: we_a = s_acc && (cnt_a_q < FULL);
      REQ_LOAD_B: we_b = s_acc && (cnt_b_q < FULL);
      default: ;
    endcase
  end

  spa_store #(.DEPTH(TERMS_PER_POLY), .AW(AW)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i (in_term),
    .raddr_i (idx_a_q[AW-1:0]),
    .rdata_o (rd_a)
  );

  spa_store #(.DEPTH(TERMS_PER_POLY), .AW(AW)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i (in_term),
    .raddr_i (idx_b_q[AW-1:0]),
    .rdata_o (rd_b)
  );

  // One exponent compare and one 17-bit add per merge step.
  assign a_has    = idx_a_q < cnt_a_q;
  assign b_has    = idx_b_q < cnt_b_q;
  assign coef_a_x = {rd_a.coef[COEF_W-1], rd_a.coef};
  assign coef_b_x = {rd_b.coef[COEF_W-1], rd_b.coef};
  assign sum      = coef_a_x + coef_b_x;
  assign a_gt     = rd_a.expon > rd_b.expon;
  assign a_lt     = rd_a.expon < rd_b.expon;

  always_comb begin
    emit    = 1'b0;
    adv_a   = 1'b0;
    adv_b   = 1'b0;
    done    = 1'b0;
    new_res = '{term_valid: 1'b1, coef: coef_a_x, expon: rd_a.expon};
    if (a_has && b_has) begin
      if (a_gt) begin
        emit  = 1'b1;
        adv_a = 1'b1;
      end else if (a_lt) begin
        emit    = 1'b1;
        adv_b   = 1'b1;
        new_res = '{term_valid: 1'b1, coef: coef_b_x, expon: rd_b.expon};
      end else begin
        // Equal exponents: sum, and drop the term if it cancels.
        emit    = (sum != '0);
        adv_a   = 1'b1;
        adv_b   = 1'b1;
        new_res = '{term_valid: 1'b1, coef: sum, expon: rd_a.expon};
      end
    end else if (a_has) begin
      emit  = 1'b1;
      adv_a = 1'b1;
    end else if (b_has) begin
      emit    = 1'b1;
      adv_b   = 1'b1;
      new_res = '{term_valid: 1'b1, coef: coef_b_x, expon: rd_b.expon};
    end else begin
      done = 1'b1;
    end
  end

  // Output register can take a word when empty or being drained this cycle.
  assign slot_free = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d    = state_q;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    idx_a_d    = idx_a_q;
    idx_b_d    = idx_b_q;
    ovf_d      = ovf_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_res_d  = out_res_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          unique case (req)
            REQ_LOAD_A: begin
              if (we_a) cnt_a_d = cnt_a_q + 1'b1;
              else      ovf_d   = 1'b1;
            end
            REQ_LOAD_B: begin
              if (we_b) cnt_b_d = cnt_b_q + 1'b1;
              else      ovf_d   = 1'b1;
            end
            REQ_RUN: begin
              idx_a_d = '0;
              idx_b_d = '0;
              state_d = ST_FETCH;
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        // Store reads issue at this edge; data is valid in ST_MERGE.
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (done) begin
          state_d = ST_FINISH;
        end else if (!emit) begin
          idx_a_d = idx_a_q + CW'(adv_a);
          idx_b_d = idx_b_q + CW'(adv_b);
          state_d = ST_FETCH;
        end else if (!pend_vld_q || slot_free) begin
          // Hold the newest term back so the final one can be marked last.
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_res_d  = pend_q;
            out_last_d = 1'b0;
            out_ovf_d  = ovf_q;
          end
          pend_vld_d = 1'b1;
          pend_d     = new_res;
          idx_a_d    = idx_a_q + CW'(adv_a);
          idx_b_d    = idx_b_q + CW'(adv_b);
          state_d    = ST_FETCH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_res_d  = pend_vld_q ? pend_q : '0;
          out_last_d = 1'b1;
          out_ovf_d  = ovf_q;
          pend_vld_d = 1'b0;
          cnt_a_d    = '0;
          cnt_b_d    = '0;
          ovf_d      = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      idx_a_q    <= '0;
      idx_b_q    <= '0;
      ovf_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
      idx_a_q    <= idx_a_d;
      idx_b_q    <= idx_b_d;
      ovf_q      <= ovf_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_res_q.expon, out_res_q.coef};
  assign m_axis_tuser  = {out_ovf_q, out_res_q.term_valid};
  assign m_axis_tlast  = out_last_q;

endmodule
